// ===== hw/rtl/bba_pkg.sv =====
// bba_pkg: shared types, codes and defaults of the buddy block allocator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package bba_pkg;

    // Defaults for top-level parameters
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int OWNER_BITS_DEF = 16;

    // Fixed field widths and queue depth
    localparam int EXP_W     = 5;
    localparam int OWNER_MAX = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [EXP_W-1:0] ORDER_RESET = 5'd10;
    // Largest request that still fits an exponent below the limit (2^30)
    localparam logic [30:0] SIZE_LIMIT = 31'h4000_0000;

    // Input operation code
    localparam logic FUNC_QUERY = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_TOTAL_ORDER = 1'b0;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_LIST_FULL = 2'd2,
        STAT_TOO_LARGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_QUERY,
        OP_TOO_LARGE
    } t_op;

    // Command handed from front to back through the queue
    typedef struct packed {
        t_op                  op;
        logic [EXP_W-1:0]     exp;
        logic [OWNER_MAX-1:0] owner;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_FILL,
        S_RES,
        S_QUERY
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/bba_front.sv =====
// bba_front: accepts input transactions and classifies them into commands.
// Depends on bba_pkg (t_cmd, op codes, size limit).
`default_nettype none
module bba_front (
    input  wire logic          i_valid,
    input  wire logic          i_func,
    input  wire logic [15:0]   i_owner_id,
    input  wire logic [30:0]   i_request_size,
    input  wire logic          i_q_full,
    input  wire logic          i_busy,
    output logic               o_stall,
    output logic               o_push,
    output bba_pkg::t_cmd      o_cmd
);

    // Ceiling log2 helper: position of the top set bit of (size - 1), plus one
    function automatic logic [bba_pkg::EXP_W-1:0] f_top_bit(input logic [29:0] d);
        logic [bba_pkg::EXP_W-1:0] r;
        r = '0;
        for (int b = 0; b < 30; b++) begin
            if (d[b]) r = bba_pkg::EXP_W'(b + 1);
        end
        return r;
    endfunction

    logic [30:0] w_dec;

    assign o_stall = i_q_full || i_busy;
    assign o_push  = i_valid && !o_stall;

    // A zero size counts as one
    assign w_dec = (i_request_size == 31'd0) ? 31'd0 : i_request_size - 31'd1;

    // Classify the transaction
    always_comb begin
        o_cmd.owner = bba_pkg::OWNER_MAX'(i_owner_id);
        o_cmd.exp   = f_top_bit(w_dec[29:0]);
        if (i_func == bba_pkg::FUNC_QUERY) begin
            o_cmd.op = bba_pkg::OP_QUERY;
        end else if (i_request_size > bba_pkg::SIZE_LIMIT) begin
            o_cmd.op = bba_pkg::OP_TOO_LARGE;
        end else begin
            o_cmd.op = bba_pkg::OP_ALLOC;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bba_queue.sv =====
// bba_queue: two-entry command queue between front and back.
// Depends on bba_pkg (t_cmd, QUEUE_DEPTH).
`default_nettype none
module bba_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bba_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output bba_pkg::t_cmd      o_cmd
);

    bba_pkg::t_cmd r_slot [bba_pkg::QUEUE_DEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'(bba_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

    // Pointer and fill count
    always_comb begin
        n_wp  = i_push ? !r_wp : r_wp;
        n_rp  = i_pop  ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bba_back.sv =====
// bba_back: block list memory and the sequencer that scans, splits and
// streams it, plus the output register. Depends on bba_pkg.
`default_nettype none
module bba_back #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_init,
    input  wire logic [bba_pkg::EXP_W-1:0] i_total_order,
    input  wire logic                      i_q_valid,
    input  wire bba_pkg::t_cmd             i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_busy,
    input  wire logic                      i_stall,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [6:0]                     o_block_count,
    output logic [15:0]                    o_block_owner,
    output logic                           o_last
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = LW + 6;
    localparam int EW = bba_pkg::EXP_W;
    localparam int DW = EW + OWNER_BITS;

    // Block list: {exponent, holder} per entry
    logic [DW-1:0] r_mem [MAX_BLOCKS];
    logic [DW-1:0] r_rdata;
    logic [IW-1:0] w_raddr, w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_we;

    bba_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_len, n_len, r_idx, n_idx;
    logic            r_pv, n_pv, r_fe, n_fe, r_fb, n_fb, r_sv, n_sv, r_init, n_init;
    logic [IW-1:0]   r_pidx, n_pidx, r_exact, n_exact, r_big, n_big;
    logic [IW-1:0]   r_pick, n_pick, r_k, n_k, r_sk, n_sk;
    logic [EW-1:0]   r_bexp, n_bexp, r_e, n_e, r_s, n_s, r_j, n_j;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    bba_pkg::t_status r_status, n_status;

    logic        r_o_valid, n_o_valid, r_o_last, n_o_last;
    logic [1:0]  r_o_status, n_o_status;
    logic [6:0]  r_o_count, n_o_count;
    logic [15:0] r_o_owner, n_o_owner;

    logic [EW-1:0]         w_rd_exp, w_pexp, w_diff;
    logic [OWNER_BITS-1:0] w_rd_hold;
    logic [31:0]           w_hold32, w_len32;
    logic [LW-1:0]         w_idx_inc;
    logic                  w_free, w_found, w_full, w_q_last;

    assign w_rd_exp  = r_rdata[DW-1 -: EW];
    assign w_rd_hold = r_rdata[OWNER_BITS-1:0];
    assign w_hold32  = 32'(w_rd_hold);
    assign w_len32   = 32'(r_len);
    assign w_idx_inc = r_idx + LW'(1);
    assign w_free    = !r_o_valid || !i_stall;
    assign w_q_last  = (r_idx == r_len - LW'(1));

    // Choice of block and list-room check
    assign w_found = r_fe || r_fb;
    assign w_pexp  = r_fe ? r_e : r_bexp;
    assign w_diff  = w_pexp - r_e;
    assign w_full  = (CW'(r_len) + CW'(w_diff)) > CW'(MAX_BLOCKS);

    assign o_busy        = r_init;
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_block_count = r_o_count;
    assign o_block_owner = r_o_owner;
    assign o_last        = r_o_last;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (!r_init && i_q_valid) begin
                    case (i_q_cmd.op)
                        bba_pkg::OP_ALLOC: n_state = bba_pkg::S_SCAN;
                        bba_pkg::OP_QUERY: n_state = bba_pkg::S_QUERY;
                        default:           n_state = bba_pkg::S_RES;
                    endcase
                end
            end
            bba_pkg::S_SCAN: begin
                if (!r_pv) n_state = bba_pkg::S_DECIDE;
            end
            bba_pkg::S_DECIDE: begin
                if (!w_found || w_full) n_state = bba_pkg::S_RES;
                else if (w_diff == '0)  n_state = bba_pkg::S_FILL;
                else                    n_state = bba_pkg::S_SHIFT;
            end
            bba_pkg::S_SHIFT: begin
                if (!(r_k > r_pick) && !r_sv) n_state = bba_pkg::S_FILL;
            end
            bba_pkg::S_FILL: begin
                if (r_j == '0) n_state = bba_pkg::S_RES;
            end
            bba_pkg::S_RES: begin
                if (w_free) n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_QUERY: begin
                if (w_free && w_q_last) n_state = bba_pkg::S_IDLE;
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory controls and outputs
    always_comb begin
        n_len = r_len;   n_idx = r_idx;   n_pv = r_pv;     n_fe = r_fe;
        n_fb = r_fb;     n_sv = r_sv;     n_init = r_init; n_pidx = r_pidx;
        n_exact = r_exact; n_big = r_big; n_pick = r_pick; n_k = r_k;
        n_sk = r_sk;     n_bexp = r_bexp; n_e = r_e;       n_s = r_s;
        n_j = r_j;       n_owner = r_owner; n_status = r_status;
        n_o_valid = r_o_valid && i_stall;
        n_o_status = r_o_status; n_o_count = r_o_count;
        n_o_owner = r_o_owner;   n_o_last = r_o_last;
        o_q_pop = 1'b0;
        w_raddr = r_idx[IW-1:0];
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (r_init) begin
                    // Rebuild the list as one free block
                    w_we    = 1'b1;
                    w_wdata = {i_total_order, {OWNER_BITS{1'b0}}};
                    n_len   = LW'(1);
                    n_init  = 1'b0;
                end else if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_e      = i_q_cmd.exp;
                    n_owner  = OWNER_BITS'(i_q_cmd.owner);
                    w_raddr  = '0;
                    n_idx    = (i_q_cmd.op == bba_pkg::OP_QUERY) ? LW'(0) : LW'(1);
                    n_pv     = 1'b1;
                    n_pidx   = '0;
                    n_fe     = 1'b0;
                    n_fb     = 1'b0;
                    n_status = bba_pkg::STAT_TOO_LARGE;
                end
            end
            bba_pkg::S_SCAN: begin
                // Check the entry read last cycle, issue the next read
                if (r_pv && w_rd_hold == '0) begin
                    if (w_rd_exp == r_e && !r_fe) begin
                        n_fe    = 1'b1;
                        n_exact = r_pidx;
                    end
                    if (w_rd_exp > r_e && !r_fb) begin
                        n_fb   = 1'b1;
                        n_big  = r_pidx;
                        n_bexp = w_rd_exp;
                    end
                end
                if (r_idx < r_len) begin
                    w_raddr = r_idx[IW-1:0];
                    n_pv    = 1'b1;
                    n_pidx  = r_idx[IW-1:0];
                    n_idx   = w_idx_inc;
                end else begin
                    n_pv = 1'b0;
                end
            end
            bba_pkg::S_DECIDE: begin
                n_pick = r_fe ? r_exact : r_big;
                n_s    = w_diff;
                n_j    = w_diff;
                n_k    = IW'(r_len - LW'(1));
                n_sv   = 1'b0;
                if (!w_found)   n_status = bba_pkg::STAT_NO_SPACE;
                else if (w_full) n_status = bba_pkg::STAT_LIST_FULL;
            end
            bba_pkg::S_SHIFT: begin
                // Move later entries up by the split count, top first
                if (r_sv) begin
                    w_we    = 1'b1;
                    w_waddr = r_sk + IW'(r_s);
                    w_wdata = r_rdata;
                end
                if (r_k > r_pick) begin
                    w_raddr = r_k;
                    n_sv    = 1'b1;
                    n_sk    = r_k;
                    n_k     = r_k - IW'(1);
                end else begin
                    n_sv = 1'b0;
                end
            end
            bba_pkg::S_FILL: begin
                // Write the free halves, then the owned block itself
                w_we    = 1'b1;
                w_waddr = r_pick + IW'(r_j);
                if (r_j == '0) begin
                    w_wdata  = {r_e, r_owner};
                    n_len    = r_len + LW'(r_s);
                    n_status = bba_pkg::STAT_OK;
                end else begin
                    w_wdata = {EW'(r_e + r_j - EW'(1)), {OWNER_BITS{1'b0}}};
                    n_j     = r_j - EW'(1);
                end
            end
            bba_pkg::S_RES: begin
                if (w_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = w_len32[6:0];
                    n_o_owner  = '0;
                    n_o_last   = 1'b1;
                end
            end
            bba_pkg::S_QUERY: begin
                // Stream one owner per cycle; hold the read when stalled
                w_raddr = r_idx[IW-1:0];
                if (w_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = bba_pkg::STAT_OK;
                    n_o_count  = w_len32[6:0];
                    n_o_owner  = w_hold32[15:0];
                    n_o_last   = w_q_last;
                    if (!w_q_last) begin
                        n_idx   = w_idx_inc;
                        w_raddr = w_idx_inc[IW-1:0];
                    end
                end
            end
            default: begin
                n_o_valid = 1'b0;
            end
        endcase
        if (i_init) n_init = 1'b1;
    end

    // List memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_IDLE;
            r_init    <= 1'b1;
            r_len     <= LW'(1);
            r_pv      <= 1'b0;
            r_sv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_init    <= n_init;
            r_len     <= n_len;
            r_pv      <= n_pv;
            r_sv      <= n_sv;
            r_o_valid <= n_o_valid;
        end
        r_idx <= n_idx;     r_fe <= n_fe;       r_fb <= n_fb;     r_pidx <= n_pidx;
        r_exact <= n_exact; r_big <= n_big;     r_pick <= n_pick; r_k <= n_k;
        r_sk <= n_sk;       r_bexp <= n_bexp;   r_e <= n_e;       r_s <= n_s;
        r_j <= n_j;         r_owner <= n_owner; r_status <= n_status;
        r_o_status <= n_o_status; r_o_count <= n_o_count;
        r_o_owner  <= n_o_owner;  r_o_last  <= n_o_last;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// Buddy block allocator top level: APB register, front classifier, command
// queue and list back end. Depends on bba_pkg, bba_front, bba_queue, bba_back.
//
// Usage: input transactions (func, owner_id, request_size) arrive on the
// i_valid / o_stall channel; results (status, block_count, block_owner, last)
// leave on o_valid / i_stall. An allocate gives one result; a query gives one
// result per listed block, last set on the final one.
// An allocate scans the list one entry per cycle, then moves the later
// entries up one per cycle and writes the split halves one per cycle
// before its result is given. A query streams one owner per cycle while
// the receiver does not stall.
// One transaction is carried out at a time; up to two more wait in the queue.
// Reset, and every write of total_order, rebuilds the list as one free block;
// while the rebuild is pending, no input transaction is accepted.
// When the receiver stalls, the result holds in the output register and the
// list sequencer waits; the front keeps accepting until the queue is full.
`default_nettype none
module buddy_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    input  wire logic        i_func,
    input  wire logic [15:0] i_owner_id,
    input  wire logic [30:0] i_request_size,
    output logic             o_stall,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [6:0]       o_block_count,
    output logic [15:0]      o_block_owner,
    output logic             o_last,
    input  wire logic        i_stall
);

    logic [bba_pkg::EXP_W-1:0] r_total_order;
    logic          w_cfg_wr, w_push, w_q_full, w_q_valid, w_pop, w_busy;
    bba_pkg::t_cmd w_f_cmd, w_q_cmd;

    // Register access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == bba_pkg::REG_TOTAL_ORDER);
    assign prdata   = (paddr[2] == bba_pkg::REG_TOTAL_ORDER) ? 32'(r_total_order) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_order <= bba_pkg::ORDER_RESET;
        end else if (w_cfg_wr) begin
            r_total_order <= pwdata[bba_pkg::EXP_W-1:0];
        end
    end

    bba_front u_front (
        .i_valid        (i_valid),
        .i_func         (i_func),
        .i_owner_id     (i_owner_id),
        .i_request_size (i_request_size),
        .i_q_full       (w_q_full),
        .i_busy         (w_busy),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_cmd          (w_f_cmd)
    );

    bba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_f_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    bba_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .OWNER_BITS (OWNER_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_init        (w_cfg_wr),
        .i_total_order (r_total_order),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_pop),
        .o_busy        (w_busy),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_block_count (o_block_count),
        .o_block_owner (o_block_owner),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for buddy_block_allocator: random and directed
// allocate/query transactions, APB order writes, scoreboard of results.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int NBLK = 64;
    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic        func;
        logic [15:0] owner;
        logic [30:0] size;
    } t_alloc_req;

    typedef struct {
        bba_pkg::t_status status;
        logic [6:0]       count;
        logic [15:0]      owner;
        logic             last;
    } t_alloc_res;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        i_func = 0;
    logic [15:0] i_owner_id = 0;
    logic [30:0] i_request_size = 0;
    logic        o_stall, o_valid, o_last;
    logic [1:0]  o_status;
    logic [6:0]  o_block_count;
    logic [15:0] o_block_owner;
    logic        i_stall = 0;

    buddy_block_allocator i_dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Shadow copy of the block list
    logic [4:0]  exp_q [NBLK];
    logic [15:0] own_q [NBLK];
    int          len_q;

    t_alloc_req  pend_q[$];
    t_alloc_res  want_q[$];
    int          errors = 0;
    int          accepted = 0;
    bit          hold_rx = 0;
    int          hold_len = 0;

    function automatic void list_init(logic [4:0] ord);
        for (int i = 0; i < NBLK; i++) begin
            exp_q[i] = 5'd0;
            own_q[i] = 16'd0;
        end
        exp_q[0] = ord;
        len_q = 1;
    endfunction

    // Ceiling log2; 31 marks too large
    function automatic int size_exp(logic [30:0] m);
        int e;
        e = 0;
        while (e < 30 && (64'd1 << e) < m) e++;
        if ((64'd1 << e) < m) return 31;
        return e;
    endfunction

    function automatic bba_pkg::t_status alloc_apply(logic [15:0] own, logic [30:0] m);
        int e, pick, sp;
        e = size_exp(m);
        pick = -1;
        if (e == 31) return bba_pkg::STAT_TOO_LARGE;
        for (int i = 0; i < len_q && pick < 0; i++)
            if (own_q[i] == 0 && exp_q[i] == e) pick = i;
        for (int i = 0; i < len_q && pick < 0; i++)
            if (own_q[i] == 0 && exp_q[i] > e) pick = i;
        if (pick < 0) return bba_pkg::STAT_NO_SPACE;
        sp = exp_q[pick] - e;
        if (len_q + sp > NBLK) return bba_pkg::STAT_LIST_FULL;
        while (exp_q[pick] > e) begin
            exp_q[pick] = exp_q[pick] - 5'd1;
            for (int k = len_q; k > pick + 1; k--) begin
                exp_q[k] = exp_q[k-1];
                own_q[k] = own_q[k-1];
            end
            exp_q[pick+1] = exp_q[pick];
            own_q[pick+1] = 16'd0;
            len_q++;
        end
        own_q[pick] = own;
        return bba_pkg::STAT_OK;
    endfunction

    function automatic void predict(t_alloc_req r);
        t_alloc_res x;
        if (r.func == bba_pkg::FUNC_QUERY) begin
            for (int i = 0; i < len_q; i++) begin
                x.status = bba_pkg::STAT_OK;
                x.count = len_q[6:0];
                x.owner = own_q[i];
                x.last = (i == len_q - 1);
                want_q.push_back(x);
            end
        end else begin
            x.status = alloc_apply(r.owner, r.size);
            x.count = len_q[6:0];
            x.owner = 16'd0;
            x.last = 1'b1;
            want_q.push_back(x);
        end
    endfunction

    // Driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            predict('{i_func, i_owner_id, i_request_size});
            accepted++;
        end
        if (!i_valid || !o_stall) begin
            if (i_valid && !o_stall) tx_gap = $urandom_range(0, 9);
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 0;
            end else if (pend_q.size() > 0 && i_rst_n) begin
                t_alloc_req r;
                r = pend_q.pop_front();
                i_valid <= 1;
                i_func <= r.func;
                i_owner_id <= r.owner;
                i_request_size <= r.size;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Monitor and receiver stall
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            t_alloc_res w;
            if (want_q.size() == 0) begin
                $error("unexpected result status=%0d", o_status);
                errors++;
            end else begin
                w = want_q.pop_front();
                if (o_status !== w.status) begin
                    $error("status exp %0d got %0d", w.status, o_status);
                    errors++;
                end
                if (o_block_count !== w.count) begin
                    $error("block_count exp %0d got %0d", w.count, o_block_count);
                    errors++;
                end
                if (o_block_owner !== w.owner) begin
                    $error("block_owner exp %0d got %0d", w.owner, o_block_owner);
                    errors++;
                end
                if (o_last !== w.last) begin
                    $error("last exp %0d got %0d", w.last, o_last);
                    errors++;
                end
            end
            accepted++;
            rx_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) rx_gap = 0;
        end
        if (hold_rx) begin
            i_stall <= 1;
            if (hold_len > 0) hold_len--;
            else hold_rx = 0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // Watchdog
    int idle_cyc = 0;
    int acc_seen = 0;
    always @(posedge i_clk) begin
        if (accepted != acc_seen) begin
            acc_seen = accepted;
            idle_cyc = 0;
        end else if (pend_q.size() > 0 || want_q.size() > 0 || i_valid) begin
            idle_cyc++;
            if (idle_cyc >= WATCH_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (pend_q.size() > 0 || i_valid || want_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [4:0] ord);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {bba_pkg::REG_TOTAL_ORDER, 2'b00};
        pwdata <= {$urandom_range(0, 1) ? 27'h7ffffff : 27'h0, ord};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        list_init(ord);
        @(posedge i_clk);
    endtask

    function automatic void add(logic f, logic [15:0] o, logic [30:0] s);
        pend_q.push_back('{f, o, s});
    endfunction

    // Mostly small sizes, sometimes a wide range and the top bits
    function automatic logic [30:0] rnd_size(int ord);
        case ($urandom_range(0, 9))
            0: return 31'($urandom());
            1: return 31'h4000_0000 + 31'($urandom_range(0, 1));
            2: return 31'd0;
            default: return 31'($urandom_range(1, 1 << (ord > 12 ? 12 : ord)));
        endcase
    endfunction

    task automatic random_phase(int n, int ord);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0)
                add(bba_pkg::FUNC_QUERY, 16'($urandom()), 31'($urandom()));
            else
                add(1'b0, ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom()),
                    rnd_size(ord));
        end
    endtask

    initial begin
        list_init(bba_pkg::ORDER_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset order 10
        add(bba_pkg::FUNC_QUERY, 16'hffff, 31'h7fffffff);
        add(1'b0, 16'h0001, 31'd0);
        add(1'b0, 16'hffff, 31'd1);
        add(1'b0, 16'h0000, 31'd3);
        add(1'b0, 16'h1234, 31'd1024);
        add(1'b0, 16'h5555, 31'h7fffffff);
        add(1'b0, 16'haaaa, 31'h4000_0000);
        add(1'b0, 16'h0002, 31'h4000_0001);
        add(bba_pkg::FUNC_QUERY, 16'h0, 31'h0);
        wait_drain();

        // Order 0, then extremes 30 and 31
        apb_write(5'd0);
        add(1'b0, 16'h0007, 31'd2);
        add(1'b0, 16'h0007, 31'd1);
        add(1'b0, 16'h0008, 31'd1);
        add(bba_pkg::FUNC_QUERY, 16'h1, 31'h1);
        wait_drain();
        apb_write(5'd31);
        add(1'b0, 16'h0009, 31'h4000_0000);
        add(1'b0, 16'h000a, 31'd1);
        add(bba_pkg::FUNC_QUERY, 16'h1, 31'h1);
        wait_drain();
        apb_write(5'd30);
        add(1'b0, 16'h000b, 31'h4000_0000);
        add(1'b0, 16'h000c, 31'd1);
        wait_drain();
        // Fill list: many unit allocations until list full
        apb_write(5'd30);
        for (int i = 0; i < 40; i++) add(1'b0, 16'(i + 1), 31'd1);
        add(bba_pkg::FUNC_QUERY, 16'h0, 31'h0);
        wait_drain();

        // Back pressure: receiver holds while sender keeps offering
        apb_write(5'd6);
        hold_len = 400;
        hold_rx = 1;
        random_phase(30, 6);
        wait_drain();

        // Random phases over several orders
        apb_write(5'd12);
        random_phase(120, 12);
        wait_drain();
        apb_write(5'd5);
        random_phase(60, 5);
        wait_drain();
        apb_write(5'd20);
        random_phase(100, 20);
        wait_drain();
        apb_write(5'd9);
        random_phase(60, 9);
        wait_drain();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_front.sv
hw/rtl/bba_queue.sv
hw/rtl/bba_back.sv
hw/rtl/buddy_block_allocator.sv
verif/testbench.sv
